/* rtl/hse_pkg.sv */
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the heap sort engine
// Controller states and the command and status words that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package hse_pkg;

  // Default store depth; legal range is 2 to 64
  localparam int DEPTH_DEFAULT = 64;

  localparam int DATA_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_BUILD_NEXT,
    ST_RD_POS,
    ST_LD_POS,
    ST_DESCEND,
    ST_CMP,
    ST_EXT_NEXT,
    ST_EXT_RD,
    ST_EXT_LD,
    ST_EMIT
  } state_t;

  // Datapath commands, at most one set per cycle
  typedef struct packed {
    logic load;       // store incoming word or flag overflow
    logic init;       // latch heap size, k = size / 2
    logic build_pick; // pos = k - 1, k--, sift size = heap size
    logic rd_pos;     // read slot at pos
    logic ld_pos;     // hold value read from pos
    logic rd_kids;    // read both children of pos
    logic step;       // move larger child up, pos = child
    logic put;        // drop held value into slot pos
    logic ext_init;   // k = heap size for extraction
    logic ext_rd;     // read root and slot k - 1
    logic ext_ld;     // root to slot k - 1, hold old slot value, restart at root
    logic emit_init;  // output index = 0
    logic emit;       // read next output slot
  } dp_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic k_zero;
    logic k_gt1;
    logic has_kids;
    logic go_down;
    logic emit_last;
  } dp_stat_t;

endpackage

/* rtl/hse_dp.sv */
// ----------------------------------------------------------------------------
// hse_dp: heap sort datapath
// Heap store (one write, two registered reads), counters, the value carried
// down during sift-down, the child compare, and the result registers.
// ----------------------------------------------------------------------------
module hse_dp #(
  parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hse_pkg::dp_cmd_t                  cmd,
  output hse_pkg::dp_stat_t                 stat,
  input  logic signed [hse_pkg::DATA_W-1:0] value,
  output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
  output logic                              run_end,
  output logic                              dropped,
  output logic                              strobe
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  // Heap store
  logic signed [hse_pkg::DATA_W-1:0] mem [DEPTH];
  logic signed [hse_pkg::DATA_W-1:0] rd_a;
  logic signed [hse_pkg::DATA_W-1:0] rd_b;
  logic [AW-1:0]                     raddr_a;
  logic [AW-1:0]                     raddr_b;
  logic                              we;
  logic [AW-1:0]                     waddr;
  logic signed [hse_pkg::DATA_W-1:0] wdata;

  // Control registers
  logic [CW-1:0] fill;
  logic          overflow;
  logic [CW-1:0] heap_n;
  logic [CW-1:0] k;
  logic [CW-1:0] sn;
  logic [AW-1:0] pos;
  logic [AW-1:0] idx;
  logic signed [hse_pkg::DATA_W-1:0] cur_val;

  logic [CW:0]   left;
  logic [CW:0]   right;
  logic [CW-1:0] km1;
  logic          full;
  logic          right_ok;
  logic          pick_right;
  logic [AW-1:0] pick_addr;
  logic signed [hse_pkg::DATA_W-1:0] pick_val;

  // Child indexes and compare
  always_comb begin
    left       = ((CW+1)'(pos) << 1) + (CW+1)'(1);
    right      = left + (CW+1)'(1);
    km1        = k - CW'(1);
    full       = (fill == CW'(DEPTH));
    right_ok   = (right < {1'b0, sn});
    pick_right = right_ok && (rd_b > rd_a);
    pick_val   = pick_right ? rd_b : rd_a;
    pick_addr  = pick_right ? right[AW-1:0] : left[AW-1:0];
  end

  // Status to controller
  always_comb begin
    stat.k_zero    = (k == '0);
    stat.k_gt1     = (k > CW'(1));
    stat.has_kids  = (left < {1'b0, sn});
    stat.go_down   = (pick_val > cur_val);
    stat.emit_last = (CW'(idx) == heap_n - CW'(1));
  end

  // Read address select
  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    if (cmd.rd_pos) begin
      raddr_a = pos;
    end else if (cmd.rd_kids) begin
      raddr_a = left[AW-1:0];
      raddr_b = right[AW-1:0];
    end else if (cmd.ext_rd) begin
      raddr_b = km1[AW-1:0];
    end else if (cmd.emit) begin
      raddr_a = idx;
    end
  end

  // Write port select
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = value;
    if (cmd.load) begin
      we    = !full;
      waddr = fill[AW-1:0];
      wdata = value;
    end else if (cmd.step) begin
      we    = 1'b1;
      waddr = pos;
      wdata = pick_val;
    end else if (cmd.put) begin
      we    = 1'b1;
      waddr = pos;
      wdata = cur_val;
    end else if (cmd.ext_ld) begin
      we    = 1'b1;
      waddr = km1[AW-1:0];
      wdata = rd_a;
    end
  end

  // Store write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  // Fill count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        fill <= fill + CW'(1);
      end
    end else if (cmd.emit && stat.emit_last) begin
      fill     <= '0;
      overflow <= 1'b0;
    end
  end

  // Sort counters and carried value
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_n <= '0;
      k      <= '0;
      sn     <= '0;
      pos    <= '0;
      idx    <= '0;
    end else begin
      if (cmd.init) begin
        heap_n <= fill;
        k      <= fill >> 1;
      end
      if (cmd.build_pick) begin
        pos <= km1[AW-1:0];
        k   <= km1;
        sn  <= heap_n;
      end
      if (cmd.step) begin
        pos <= pick_addr;
      end
      if (cmd.ext_init) begin
        k <= heap_n;
      end
      if (cmd.ext_ld) begin
        pos <= '0;
        sn  <= km1;
        k   <= km1;
      end
      if (cmd.emit_init) begin
        idx <= '0;
      end
      if (cmd.emit) begin
        idx <= idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_pos) begin
      cur_val <= rd_a;
    end else if (cmd.ext_ld) begin
      cur_val <= rd_b;
    end
  end

  // Result word: data comes from the registered read, flags registered alongside it
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe  <= 1'b0;
      run_end <= 1'b0;
      dropped <= 1'b0;
    end else begin
      strobe  <= cmd.emit;
      run_end <= cmd.emit && stat.emit_last;
      dropped <= cmd.emit && overflow;
    end
  end

  assign sorted_value = rd_a;

endmodule

/* rtl/hse_ctrl.sv */
// ----------------------------------------------------------------------------
// hse_ctrl: heap sort controller
// Sequences loading, bottom-up heap build, root extraction and output.
// ----------------------------------------------------------------------------
module hse_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               last_item,
  input  hse_pkg::dp_stat_t  stat,
  output hse_pkg::dp_cmd_t   cmd,
  output logic               busy
);

  hse_pkg::state_t state;
  hse_pkg::state_t state_next;
  logic            extracting;
  logic            extracting_next;
  hse_pkg::state_t sift_ret;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hse_pkg::ST_IDLE;
      extracting <= 1'b0;
    end else begin
      state      <= state_next;
      extracting <= extracting_next;
    end
  end

  // Where a finished sift-down goes back to
  assign sift_ret = extracting ? hse_pkg::ST_EXT_NEXT : hse_pkg::ST_BUILD_NEXT;

  // Next state and commands
  always_comb begin
    state_next      = state;
    extracting_next = extracting;
    cmd             = '0;
    unique case (state)
      hse_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (last_item) begin
            state_next = hse_pkg::ST_INIT;
          end
        end
      end
      hse_pkg::ST_INIT: begin
        cmd.init        = 1'b1;
        extracting_next = 1'b0;
        state_next      = hse_pkg::ST_BUILD_NEXT;
      end
      hse_pkg::ST_BUILD_NEXT: begin
        if (stat.k_zero) begin
          cmd.ext_init    = 1'b1;
          extracting_next = 1'b1;
          state_next      = hse_pkg::ST_EXT_NEXT;
        end else begin
          cmd.build_pick = 1'b1;
          state_next     = hse_pkg::ST_RD_POS;
        end
      end
      hse_pkg::ST_RD_POS: begin
        cmd.rd_pos = 1'b1;
        state_next = hse_pkg::ST_LD_POS;
      end
      hse_pkg::ST_LD_POS: begin
        cmd.ld_pos = 1'b1;
        state_next = hse_pkg::ST_DESCEND;
      end
      hse_pkg::ST_DESCEND: begin
        if (stat.has_kids) begin
          cmd.rd_kids = 1'b1;
          state_next  = hse_pkg::ST_CMP;
        end else begin
          cmd.put    = 1'b1;
          state_next = sift_ret;
        end
      end
      hse_pkg::ST_CMP: begin
        if (stat.go_down) begin
          cmd.step   = 1'b1;
          state_next = hse_pkg::ST_DESCEND;
        end else begin
          cmd.put    = 1'b1;
          state_next = sift_ret;
        end
      end
      hse_pkg::ST_EXT_NEXT: begin
        if (stat.k_gt1) begin
          state_next = hse_pkg::ST_EXT_RD;
        end else begin
          cmd.emit_init = 1'b1;
          state_next    = hse_pkg::ST_EMIT;
        end
      end
      hse_pkg::ST_EXT_RD: begin
        cmd.ext_rd = 1'b1;
        state_next = hse_pkg::ST_EXT_LD;
      end
      hse_pkg::ST_EXT_LD: begin
        cmd.ext_ld = 1'b1;
        state_next = hse_pkg::ST_DESCEND;
      end
      hse_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.emit_last) begin
          state_next = hse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hse_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != hse_pkg::ST_IDLE);

endmodule

/* rtl/heap_sort_engine_core.sv */
// ----------------------------------------------------------------------------
// heap_sort_engine_core: heapsort engine on a binary max-heap
// Collects signed words, sorts them in place and streams them out ascending.
// ----------------------------------------------------------------------------
// A word is taken on each clock edge with start high and busy low, so loading
// runs at one word per cycle. Words past DEPTH are discarded and flag every
// result of that set as dropped. The word with last_item high closes the set;
// busy then rises for the sort. Each level of a sift-down reads both children,
// then compares them and moves the larger one up over the single-write, dual-read
// heap store. Each of the roughly 3*n/2 sift-downs for a set of n words first
// reads and holds its starting value and ends by writing the held value into
// its final slot. Results then come out one per cycle,
// each held for exactly one cycle with strobe high; there is no backpressure,
// so the receiver must take every word as it appears. run_end marks the last
// and largest word. The next set may start loading on the cycle of that word.
// ----------------------------------------------------------------------------
module heap_sort_engine_core #(
  parameter int DEPTH = hse_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [hse_pkg::DATA_W-1:0] value,
  input  logic                              last_item,
  output logic                              strobe,
  output logic signed [hse_pkg::DATA_W-1:0] sorted_value,
  output logic                              run_end,
  output logic                              dropped
);

  hse_pkg::dp_cmd_t  cmd;
  hse_pkg::dp_stat_t stat;

  // Sequencer
  hse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (last_item),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  // Store and arithmetic
  hse_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .value        (value),
    .sorted_value (sorted_value),
    .run_end      (run_end),
    .dropped      (dropped),
    .strobe       (strobe)
  );

  // A closing word always starts a sort
  a_last_starts_sort: assert property (@(posedge clk) disable iff (rst)
    start && !busy && last_item |=> busy)
    else $error("closing word did not start a sort");

  // Results only come out of a sort
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result word without a preceding sort");

  // The last word of a run ends the output stream
  a_end_stops_stream: assert property (@(posedge clk) disable iff (rst)
    strobe && run_end |=> !strobe)
    else $error("result word after end of run");

  // Flags only ride on result words
  a_flags_with_strobe: assert property (@(posedge clk) disable iff (rst)
    (run_end || dropped) |-> strobe)
    else $error("result flag without strobe");

endmodule
